// ----- hw/rtl/lruwb_pkg.sv -----
// shared types and constants for the lru write-back cache with victim buffer
// no dependencies
package lruwb_pkg;
	localparam int MaxSets = 256;
	localparam int MaxWays = 8;
	localparam int MaxVictim = 16;
	localparam int AddrWidth = 32;
	localparam int SetW = $clog2(MaxSets);
	localparam int WayW = $clog2(MaxWays);
	localparam int VicW = $clog2(MaxVictim);
	localparam int BlkW = AddrWidth - 2;
	localparam int RankW = 3;
	localparam int VRankW = 4;

	localparam logic [1:0] RegOffset = 2'd0;
	localparam logic [1:0] RegIndex = 2'd1;
	localparam logic [1:0] RegWays = 2'd2;
	localparam logic [1:0] RegVictim = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_UPD,
		ST_CLR
	} state_t;

	typedef struct packed {
		logic look;
		logic upd;
		logic clr;
	} cmd_t;

	typedef struct packed {
		logic clr_req;
		logic clr_done;
	} stat_t;
endpackage

// ----- hw/rtl/lru_writeback_cache_with_victim_buffer.sv -----
// top level of the lru write-back cache with victim buffer
// depends on lruwb_pkg, lruwb_ctrl, lruwb_dp
// channel   | handshake            | payload
// command   | start, busy          | op, address
// result    | done (one cycle)     | hit, victim_swap, fetch_request, writeback_valid, wb_addr
// config    | cfg_we               | cfg_idx, cfg_data
// a word is accepted at an edge with start high and busy low, the set memory is read there
// the next cycle does lookup and update, done is strobed in the cycle after that
// busy stays high until the result cycle ends, so a new access is not taken before the last one's result
// after reset a clearing pass over all 256 sets clears the set memory with busy high
// a ways_in_use write keeps busy high while a pass over every set rewrites the line ranks
// results are strobed for one cycle and cannot be stalled
module lru_writeback_cache_with_victim_buffer import lruwb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic op,
	input logic [AddrWidth-1:0] address,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [4:0] cfg_data,
	output logic done,
	output logic hit,
	output logic victim_swap,
	output logic fetch_request,
	output logic writeback_valid,
	output logic [AddrWidth-1:0] wb_addr
);
	cmd_t cmd;
	stat_t stat;

	lruwb_ctrl u_ctrl (.clk, .arst_n, .start, .stat, .busy, .cmd);
	lruwb_dp u_dp (.clk, .arst_n, .cmd, .stat, .cfg_we, .cfg_idx, .cfg_data, .op, .address,
		.done, .hit, .victim_swap, .fetch_request, .writeback_valid, .wb_addr);
endmodule

// ----- hw/rtl/lruwb_ctrl.sv -----
// controller state machine: read cycle, update cycle, clearing pass
// depends on lruwb_pkg
module lruwb_ctrl import lruwb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input stat_t stat,
	output logic busy,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (stat.clr_req) state_d = ST_CLR;
				else begin
					busy = 1'b0;
					if (start) begin
						cmd.look = 1'b1;
						state_d = ST_LOOK;
					end
				end
			end
			ST_LOOK: begin
				cmd.upd = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: state_d = ST_IDLE;
			ST_CLR: begin
				cmd.clr = 1'b1;
				if (stat.clr_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	property p_upd_after_look;
		@(posedge clk) disable iff (!arst_n) state_q == ST_LOOK |=> state_q == ST_UPD;
	endproperty
	a_upd_after_look: assert property (p_upd_after_look) else $error("look not followed by update");

	property p_idle_not_busy;
		@(posedge clk) disable iff (!arst_n)
			busy == (state_q != ST_IDLE || stat.clr_req);
	endproperty
	a_idle_not_busy: assert property (p_idle_not_busy) else $error("busy mismatch");

	property p_clr_exit;
		@(posedge clk) disable iff (!arst_n) (state_q == ST_CLR && stat.clr_done) |=> state_q == ST_IDLE;
	endproperty
	a_clr_exit: assert property (p_clr_exit) else $error("clear pass exit");
endmodule

// ----- hw/rtl/lruwb_dp.sv -----
// datapath: set memory, victim buffer, lookup and replacement
// depends on lruwb_pkg
module lruwb_dp import lruwb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cmd_t cmd,
	output stat_t stat,
	input logic cfg_we,
	input logic [1:0] cfg_idx,
	input logic [4:0] cfg_data,
	input logic op,
	input logic [AddrWidth-1:0] address,
	output logic done,
	output logic hit,
	output logic victim_swap,
	output logic fetch_request,
	output logic writeback_valid,
	output logic [AddrWidth-1:0] wb_addr
);
	typedef struct packed {
		logic v;
		logic d;
		logic [BlkW-1:0] b;
	} line_t;
	typedef line_t [MaxWays-1:0] row_t;
	typedef logic [MaxWays-1:0][RankW-1:0] rank_row_t;

	row_t mem [MaxSets];
	rank_row_t rank_mem [MaxSets];
	row_t row_s1;
	rank_row_t rank_s1;
	logic [SetW-1:0] clr_q;
	logic init_q;
	logic rk_pend_q;
	logic [2:0] off_q;
	logic [3:0] idx_q;
	logic [3:0] ways_q;
	logic [4:0] vic_q;

	logic v_v_q [MaxVictim];
	logic v_d_q [MaxVictim];
	logic [VRankW-1:0] v_r_q [MaxVictim];
	logic [BlkW-1:0] v_b_q [MaxVictim];

	logic op_s1;
	logic [BlkW-1:0] blk_s1;
	logic [SetW-1:0] set_s1;
	logic [2:0] offe_s1;

	logic [2:0] off_e;
	logic [BlkW-1:0] blk_c;
	logic [SetW-1:0] set_c;
	logic [WayW:0] w_e;
	logic [VicW:0] n_e;
	rank_row_t rank_fill;

	always_comb begin
		off_e = (off_q < 3'd2) ? 3'd2 : off_q;
		blk_c = BlkW'(address >> off_e);
		set_c = SetW'(blk_c & ((BlkW'(1) << idx_q) - BlkW'(1)));
		if (ways_q == 4'd0) w_e = (WayW+1)'(1);
		else if (ways_q > 4'(MaxWays)) w_e = (WayW+1)'(MaxWays);
		else w_e = (WayW+1)'(ways_q);
		n_e = (vic_q > 5'(MaxVictim)) ? (VicW+1)'(MaxVictim) : (VicW+1)'(vic_q);
		for (int k = 0; k < MaxWays; k++) rank_fill[k] = RankW'(w_e - 1'b1);
	end

	logic hit_f, inv_f, vhit_f, vinv_f;
	logic [WayW-1:0] hw, iw, lw;
	logic [VicW-1:0] he, ie, le;
	logic [RankW-1:0] lr;
	logic [VRankW-1:0] vr;
	always_comb begin
		hit_f = 1'b0; inv_f = 1'b0; hw = '0; iw = '0; lw = '0; lr = rank_s1[0];
		for (int k = MaxWays-1; k >= 0; k--) begin
			if (k < w_e) begin
				if (row_s1[k].v && row_s1[k].b == blk_s1) begin
					hit_f = 1'b1; hw = WayW'(k);
				end
				if (!row_s1[k].v) begin
					inv_f = 1'b1; iw = WayW'(k);
				end
			end
		end
		for (int k = 1; k < MaxWays; k++)
			if (k < w_e && rank_s1[k] > lr) begin
				lr = rank_s1[k]; lw = WayW'(k);
			end
		vhit_f = 1'b0; vinv_f = 1'b0; he = '0; ie = '0; le = '0; vr = v_r_q[0];
		for (int k = MaxVictim-1; k >= 0; k--) begin
			if (k < n_e) begin
				if (v_v_q[k] && v_b_q[k] == blk_s1) begin
					vhit_f = 1'b1; he = VicW'(k);
				end
				if (!v_v_q[k]) begin
					vinv_f = 1'b1; ie = VicW'(k);
				end
			end
		end
		for (int k = 1; k < MaxVictim; k++)
			if (k < n_e && v_r_q[k] > vr) begin
				vr = v_r_q[k]; le = VicW'(k);
			end
	end

	logic [WayW-1:0] tw;
	logic [VicW-1:0] te;
	logic use_vic, do_swap, wb_c;
	logic [BlkW-1:0] wb_blk;
	row_t row_n;
	rank_row_t rank_n;
	always_comb begin
		use_vic = !hit_f && !inv_f && n_e != '0;
		do_swap = use_vic && vhit_f;
		tw = hit_f ? hw : (inv_f ? iw : lw);
		te = do_swap ? he : (vinv_f ? ie : le);
		wb_c = 1'b0; wb_blk = '0;
		if (!hit_f && !inv_f) begin
			if (use_vic) begin
				if (!vhit_f && !vinv_f && v_d_q[le]) begin
					wb_c = 1'b1; wb_blk = v_b_q[le];
				end
			end else if (row_s1[lw].d) begin
				wb_c = 1'b1; wb_blk = row_s1[lw].b;
			end
		end
		row_n = row_s1;
		rank_n = rank_s1;
		for (int k = 0; k < MaxWays; k++)
			if (k < w_e && rank_s1[k] < rank_s1[tw]) rank_n[k] = rank_s1[k] + 1'b1;
		rank_n[tw] = '0;
		row_n[tw].v = 1'b1;
		row_n[tw].b = blk_s1;
		if (hit_f) row_n[tw].d = row_s1[tw].d | op_s1;
		else if (do_swap) row_n[tw].d = op_s1 | v_d_q[te];
		else row_n[tw].d = op_s1;
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			if (init_q) mem[clr_q] <= '0;
			rank_mem[clr_q] <= rank_fill;
		end else if (cmd.upd) begin
			mem[set_s1] <= row_n;
			rank_mem[set_s1] <= rank_n;
		end
		row_s1 <= mem[set_c];
		rank_s1 <= rank_mem[set_c];
		if (cmd.look) begin
			op_s1 <= op;
			blk_s1 <= blk_c;
			set_s1 <= set_c;
			offe_s1 <= off_e;
		end
		if (cmd.upd && use_vic) begin
			v_b_q[te] <= row_s1[lw].b;
			v_d_q[te] <= row_s1[lw].d;
		end
		if (cmd.upd) wb_addr <= wb_c ? AddrWidth'({2'b0, wb_blk} << offe_s1) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= 3'd5; idx_q <= 4'd6; ways_q <= 4'd4; vic_q <= 5'd0;
			clr_q <= '0; init_q <= 1'b1; rk_pend_q <= 1'b0;
			done <= 1'b0; hit <= 1'b0; victim_swap <= 1'b0;
			fetch_request <= 1'b0; writeback_valid <= 1'b0;
			for (int k = 0; k < MaxVictim; k++) begin
				v_v_q[k] <= 1'b0; v_r_q[k] <= '0;
			end
		end else begin
			done <= cmd.upd;
			hit <= cmd.upd & hit_f;
			victim_swap <= cmd.upd & do_swap;
			fetch_request <= cmd.upd & !hit_f & !do_swap;
			writeback_valid <= cmd.upd & wb_c;
			// a ways write restarts the rank pass
			if (cfg_we && cfg_idx == RegWays) begin
				clr_q <= '0;
				rk_pend_q <= 1'b1;
			end else if (cmd.clr) begin
				clr_q <= clr_q + 1'b1;
				rk_pend_q <= 1'b0;
			end
			if (cmd.clr && stat.clr_done) init_q <= 1'b0;
			if (cmd.upd) begin
				if (use_vic) begin
					v_v_q[te] <= 1'b1;
					for (int k = 0; k < MaxVictim; k++)
						if (k < n_e && v_r_q[k] < v_r_q[te]) v_r_q[k] <= v_r_q[k] + 1'b1;
					v_r_q[te] <= '0;
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					RegOffset: off_q <= cfg_data[2:0];
					RegIndex: idx_q <= cfg_data[3:0];
					RegWays: ways_q <= cfg_data[3:0];
					RegVictim: begin
						vic_q <= cfg_data;
						for (int k = 0; k < MaxVictim; k++)
							v_r_q[k] <= (cfg_data == 5'd0) ? '0 :
								((cfg_data > 5'(MaxVictim)) ? VRankW'(MaxVictim-1)
								: VRankW'(cfg_data - 5'd1));
					end
					default: ;
				endcase
			end
		end
	end

	assign stat.clr_done = clr_q == SetW'(MaxSets-1);
	assign stat.clr_req = rk_pend_q;

	property p_wb_addr_zero;
		@(posedge clk) disable iff (!arst_n) done && !writeback_valid |-> wb_addr == '0;
	endproperty
	a_wb_addr_zero: assert property (p_wb_addr_zero) else $error("writeback address not zero");

	property p_one_kind;
		@(posedge clk) disable iff (!arst_n) done |-> $onehot({hit, victim_swap, fetch_request});
	endproperty
	a_one_kind: assert property (p_one_kind) else $error("result kinds overlap");

	property p_wb_on_fetch;
		@(posedge clk) disable iff (!arst_n) writeback_valid |-> fetch_request;
	endproperty
	a_wb_on_fetch: assert property (p_wb_on_fetch) else $error("writeback without fetch");
endmodule

// ----- verif/lru_writeback_cache_with_victim_buffer_tb.sv -----
// self-checking testbench for the lru write-back cache with victim buffer
// drives accesses and register writes, predicts each result word or takes it from a table, and compares
// depends on lruwb_pkg and lru_writeback_cache_with_victim_buffer
module lru_writeback_cache_with_victim_buffer_tb import lruwb_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic hit;
		logic swap;
		logic fetch;
		logic wbv;
		logic [31:0] wba;
	} res_t;

	typedef struct packed {
		logic wr;
		logic [31:0] addr;
		logic typed;
		res_t res;
	} row_t;

	localparam int IdleLimit = 3000;

	logic clk, arst_n, start, busy, op, cfg_we, done;
	logic [31:0] address;
	logic [1:0] cfg_idx;
	logic [4:0] cfg_data;
	logic hit, victim_swap, fetch_request, writeback_valid;
	logic [31:0] wb_addr;
	logic typed_q;
	res_t typed_res_q;

	lru_writeback_cache_with_victim_buffer DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op), .address(address),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data), .done(done), .hit(hit),
		.victim_swap(victim_swap), .fetch_request(fetch_request),
		.writeback_valid(writeback_valid), .wb_addr(wb_addr)
	);

	// cache tag store, victim buffer and register copy
	logic [31:0] l_blk [MaxSets][MaxWays];
	logic l_val [MaxSets][MaxWays];
	logic l_dirty [MaxSets][MaxWays];
	int l_rank [MaxSets][MaxWays];
	logic [31:0] v_blk [MaxVictim];
	logic v_val [MaxVictim];
	logic v_dirty [MaxVictim];
	int v_rank [MaxVictim];
	int c_off, c_idx, c_ways, c_vic;

	res_t expected_words [$];
	int errors, idle_cycles, send_pct;

	row_t reset_rows [8] = '{
		'{1'b0, 32'h4000, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 32'h0}},
		'{1'b1, 32'h4000, 1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 32'h0}},
		'{1'b0, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 32'h0}},
		'{1'b1, 32'h0800, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 32'h0}},
		'{1'b0, 32'h1000, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 32'h0}},
		'{1'b0, 32'h1800, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 32'h0}},
		'{1'b0, 32'h2000, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, 32'h4000}},
		'{1'b1, 32'h4000, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, 32'h0800}}
	};

	row_t victim_rows [10] = '{
		'{1'b1, 32'h0, 1'b0, '0}, '{1'b0, 32'h4, 1'b0, '0}, '{1'b1, 32'h8, 1'b0, '0},
		'{1'b0, 32'h0, 1'b0, '0}, '{1'b0, 32'hC, 1'b0, '0}, '{1'b1, 32'h4, 1'b0, '0},
		'{1'b0, 32'h10, 1'b0, '0}, '{1'b0, 32'h8, 1'b0, '0}, '{1'b0, 32'h14, 1'b0, '0},
		'{1'b1, 32'hFFFF_FFFC, 1'b0, '0}
	};

	int cfg_sets [8][4] = '{
		'{5, 6, 4, 0}, '{0, 0, 1, 2}, '{7, 8, 8, 16}, '{1, 15, 0, 31},
		'{2, 3, 15, 4}, '{3, 2, 2, 1}, '{7, 0, 8, 16}, '{4, 5, 3, 0}
	};

	function automatic int eff_ways();
		return c_ways == 0 ? 1 : (c_ways > MaxWays ? MaxWays : c_ways);
	endfunction

	function automatic int eff_vic();
		return c_vic > MaxVictim ? MaxVictim : c_vic;
	endfunction

	function automatic int eff_off();
		return c_off < 2 ? 2 : c_off;
	endfunction

	function automatic void touch_line(int s, int way, int w);
		int r;
		r = l_rank[s][way];
		for (int k = 0; k < w; k++)
			if (l_rank[s][k] < r) l_rank[s][k]++;
		l_rank[s][way] = 0;
	endfunction

	function automatic void touch_victim(int e, int n);
		int r;
		r = v_rank[e];
		for (int k = 0; k < n; k++)
			if (v_rank[k] < r) v_rank[k]++;
		v_rank[e] = 0;
	endfunction

	function automatic void write_reg(logic [1:0] idx, logic [4:0] val);
		case (idx)
			RegOffset: c_off = val & 7;
			RegIndex: c_idx = val & 15;
			RegWays: begin
				c_ways = val & 15;
				foreach (l_rank[s, k]) l_rank[s][k] = eff_ways() - 1;
			end
			RegVictim: begin
				c_vic = val;
				foreach (v_rank[k]) v_rank[k] = eff_vic() == 0 ? 0 : eff_vic() - 1;
			end
			default: ;
		endcase
	endfunction

	function automatic res_t cache_access(logic wr, logic [31:0] a);
		int eo, s, w, n, k, lru;
		logic [31:0] blk;
		logic d;
		res_t r;
		eo = eff_off();
		blk = a >> eo;
		s = (blk & ((32'd1 << c_idx) - 1)) % MaxSets;
		w = eff_ways();
		n = eff_vic();
		r = '0;
		for (k = 0; k < w; k++)
			if (l_val[s][k] && l_blk[s][k] == blk) begin
				if (wr) l_dirty[s][k] = 1'b1;
				touch_line(s, k, w);
				r.hit = 1'b1;
				return r;
			end
		for (k = 0; k < w; k++)
			if (!l_val[s][k]) begin
				l_blk[s][k] = blk;
				l_val[s][k] = 1'b1;
				l_dirty[s][k] = wr;
				touch_line(s, k, w);
				r.fetch = 1'b1;
				return r;
			end
		lru = 0;
		for (k = 1; k < w; k++)
			if (l_rank[s][k] > l_rank[s][lru]) lru = k;
		if (n > 0) begin
			for (k = 0; k < n; k++)
				if (v_val[k] && v_blk[k] == blk) begin
					d = l_dirty[s][lru];
					v_blk[k] = l_blk[s][lru];
					l_blk[s][lru] = blk;
					l_dirty[s][lru] = wr ? 1'b1 : v_dirty[k];
					v_dirty[k] = d;
					touch_victim(k, n);
					touch_line(s, lru, w);
					r.swap = 1'b1;
					return r;
				end
			for (k = 0; k < n; k++)
				if (!v_val[k]) break;
			if (k == n) begin
				k = 0;
				for (int j = 1; j < n; j++)
					if (v_rank[j] > v_rank[k]) k = j;
				if (v_dirty[k]) begin
					r.wbv = 1'b1;
					r.wba = v_blk[k] << eo;
				end
			end
			v_blk[k] = l_blk[s][lru];
			v_dirty[k] = l_dirty[s][lru];
			v_val[k] = 1'b1;
			touch_victim(k, n);
		end else if (l_dirty[s][lru]) begin
			r.wbv = 1'b1;
			r.wba = l_blk[s][lru] << eo;
		end
		l_blk[s][lru] = blk;
		l_val[s][lru] = 1'b1;
		l_dirty[s][lru] = wr;
		touch_line(s, lru, w);
		r.fetch = 1'b1;
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// monitor: mirrors register writes, predicts on accepted words, checks result words
	always @(posedge clk) begin
		res_t pred, got;
		int idle_n;
		if (arst_n) begin
			idle_n = idle_cycles + 1;
			if (cfg_we) write_reg(cfg_idx, cfg_data);
			if (done) begin
				idle_n = 0;
				got = '{hit, victim_swap, fetch_request, writeback_valid, wb_addr};
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected result word %h", $time, got);
					errors++;
				end else begin
					pred = expected_words.pop_front();
					if (got.hit !== pred.hit || got.swap !== pred.swap ||
							got.fetch !== pred.fetch || got.wbv !== pred.wbv ||
							got.wba !== pred.wba) begin
						$display("%0t: mismatch expected hit %b swap %b fetch %b wb %b %h",
							$time, pred.hit, pred.swap, pred.fetch, pred.wbv, pred.wba);
						$display("%0t:          actual hit %b swap %b fetch %b wb %b %h",
							$time, got.hit, got.swap, got.fetch, got.wbv, got.wba);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				idle_n = 0;
				pred = cache_access(op, address);
				expected_words.push_back(typed_q ? typed_res_q : pred);
			end
			idle_cycles <= idle_n;
			if (idle_n > IdleLimit) begin
				$display("lru_writeback_cache_with_victim_buffer test failed");
				$finish;
			end
		end
	end

	task automatic send(row_t rw);
		start <= 1'b1;
		op <= rw.wr;
		address <= rw.addr;
		typed_q <= rw.typed;
		typed_res_q <= rw.res;
		do @(posedge clk); while (busy);
		if ($urandom_range(0, 99) < send_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic set_regs(int ph);
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= i[1:0];
			cfg_data <= cfg_sets[ph][i][4:0];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic row_t rand_row();
		row_t rw;
		int eo;
		eo = eff_off();
		rw = '0;
		rw.wr = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) == 0)
			rw.addr = $urandom;
		else
			rw.addr = ($urandom_range(0, 11) << (eo + c_idx)) |
				($urandom_range(0, 3) << eo) | ($urandom & ((32'd1 << eo) - 1));
		return rw;
	endfunction

	initial begin
		errors = 0;
		idle_cycles = 0;
		send_pct = 14;
		arst_n = 1'b0;
		start = 1'b0;
		op = 1'b0;
		address = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		typed_q = 1'b0;
		typed_res_q = '0;
		c_off = 5;
		c_idx = 6;
		c_ways = 4;
		c_vic = 0;
		foreach (l_val[s, k]) begin
			l_val[s][k] = 1'b0;
			l_dirty[s][k] = 1'b0;
			l_blk[s][k] = '0;
			l_rank[s][k] = 3;
		end
		foreach (v_val[k]) begin
			v_val[k] = 1'b0;
			v_dirty[k] = 1'b0;
			v_blk[k] = '0;
			v_rank[k] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		foreach (reset_rows[i]) send(reset_rows[i]);
		settle();
		set_regs(1);
		foreach (victim_rows[i]) send(victim_rows[i]);
		settle();
		for (int ph = 0; ph < 8; ph++) begin
			send_pct = ph < 3 ? 14 : (ph < 6 ? 67 : 0);
			set_regs(ph);
			repeat (190) send(rand_row());
			settle();
		end
		if (errors == 0)
			$display("lru_writeback_cache_with_victim_buffer test passed");
		else
			$display("lru_writeback_cache_with_victim_buffer test failed");
		$finish;
	end
endmodule

// ----- lru_writeback_cache_with_victim_buffer.f -----
hw/rtl/lruwb_pkg.sv
hw/rtl/lruwb_ctrl.sv
hw/rtl/lruwb_dp.sv
hw/rtl/lru_writeback_cache_with_victim_buffer.sv
verif/lru_writeback_cache_with_victim_buffer_tb.sv
